[rtl/core/tcw_pkg.sv]
// tcw_pkg: shared constants, types and helpers of the text console writer.
// Depends on nothing; used by every module under rtl/core.
package tcw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = ROWS * COLUMNS;
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int CNT_W   = $clog2(CELLS + 1);

  localparam int FUNC_W = 2;
  localparam int CHAR_W = 8;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int OFF_W  = 11;
  localparam int CELL_W = 16;
  localparam int ATTR_W = 8;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_BIT = 2;
  localparam logic REG_TEXT_ATTRIBUTE = 1'b0;
  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

  localparam logic [FUNC_W-1:0] FN_WRITE  = 2'd0;
  localparam logic [FUNC_W-1:0] FN_CLEAR  = 2'd1;
  localparam logic [FUNC_W-1:0] FN_SETPOS = 2'd2;
  localparam logic [FUNC_W-1:0] FN_READ   = 2'd3;

  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_BLANK = 8'h20;
  localparam int TAB_STEP = 8;

  typedef enum logic [2:0] {
    OP_PUT, OP_BS, OP_TAB, OP_NL, OP_CLEAR, OP_SETPOS, OP_READ, OP_REPORT
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [CHAR_W-1:0] code;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
  } cmd_t;

  typedef struct packed {
    logic init_busy;
    logic busy;
  } status_t;

  function automatic logic [OFF_W-1:0] cell_offset(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
    logic [OFF_W-1:0] r;
    r = OFF_W'(row) * OFF_W'(COLUMNS) + OFF_W'(col);
    return r;
  endfunction

endpackage

[rtl/core/text_console_writer.sv]
// Text console writer: 80x25 screen store with cursor, APB attribute register.
// Top level; depends on tcw_pkg, tcw_front, tcw_cmd_fifo and tcw_back.
//
// After reset the block sweeps the 2000-cell screen store to zero, one cell a
// cycle, and holds full high until the sweep is done. An ordinary character, a
// cursor move or a report is executed in the idle state alone, a cell read in
// the idle and then the read state, behind one decode register and a two-word
// command queue; the one-word result register sets the pace, since no new item
// is taken until the last result word has been popped. A clear rewrites all
// 2000 cells of the store; a scroll copies 1920 cells up by one row through
// the read register and then blanks the 80 cells of the last row; items keep
// queueing up to the queue depth meanwhile.
module text_console_writer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic [tcw_pkg::FUNC_W-1:0]        func,
  input  logic [tcw_pkg::CHAR_W-1:0]        char_code,
  input  logic [tcw_pkg::ROW_W-1:0]         target_row,
  input  logic [tcw_pkg::COL_W-1:0]         target_col,
  output logic                              empty,
  input  logic                              pop,
  output logic [tcw_pkg::COL_W-1:0]         cursor_col,
  output logic [tcw_pkg::ROW_W-1:0]         cursor_row,
  output logic [tcw_pkg::OFF_W-1:0]         cursor_offset,
  output logic [tcw_pkg::CELL_W-1:0]        cell_data,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tcw_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [tcw_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [tcw_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);

  logic [tcw_pkg::ATTR_W-1:0] text_attribute;
  tcw_pkg::status_t           status;
  tcw_pkg::cmd_t              front_cmd;
  tcw_pkg::cmd_t              back_cmd;
  logic                       front_push;
  logic                       q_full;
  logic                       q_empty;
  logic                       q_pop;
  logic                       attr_sel;

  assign pready   = 1'b1;
  assign attr_sel = (paddr[tcw_pkg::REG_IDX_BIT] == tcw_pkg::REG_TEXT_ATTRIBUTE);
  assign prdata   = attr_sel ? tcw_pkg::APB_DATA_W'(text_attribute) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_attribute <= tcw_pkg::ATTR_RESET;
    end else if (psel && penable && pwrite && pready && attr_sel) begin
      text_attribute <= pwdata[tcw_pkg::ATTR_W-1:0];
    end
  end

  tcw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .func       (func),
    .char_code  (char_code),
    .target_row (target_row),
    .target_col (target_col),
    .init_busy  (status.init_busy),
    .q_full     (q_full),
    .q_push     (front_push),
    .q_cmd      (front_cmd)
  );

  tcw_cmd_fifo u_cmd_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (front_push),
    .full   (q_full),
    .wr_cmd (front_cmd),
    .pop    (q_pop),
    .empty  (q_empty),
    .rd_cmd (back_cmd)
  );

  tcw_back u_back (
    .clk           (clk),
    .rst           (rst),
    .attr          (text_attribute),
    .q_empty       (q_empty),
    .q_cmd         (back_cmd),
    .q_pop         (q_pop),
    .pop           (pop),
    .empty         (empty),
    .cursor_col    (cursor_col),
    .cursor_row    (cursor_row),
    .cursor_offset (cursor_offset),
    .cell_data     (cell_data),
    .status        (status)
  );

  a_init_blocks: assert property (@(posedge clk) disable iff (rst)
    status.init_busy |-> full && status.busy)
    else $error("input open during store clearing pass");

  a_offset: assert property (@(posedge clk) disable iff (rst)
    !empty |-> cursor_offset == tcw_pkg::cell_offset(cursor_row, cursor_col))
    else $error("cursor offset disagrees with row and column");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> ({1'b0, cursor_col} < (tcw_pkg::COL_W + 1)'(tcw_pkg::COLUMNS)) &&
               ({1'b0, cursor_row} < (tcw_pkg::ROW_W + 1)'(tcw_pkg::ROWS)))
    else $error("cursor outside the screen");

endmodule

[rtl/core/tcw_front.sv]
// tcw_front: accepts input words, decodes them into console commands.
// Depends on tcw_pkg; feeds tcw_cmd_fifo.
module tcw_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [tcw_pkg::FUNC_W-1:0]    func,
  input  logic [tcw_pkg::CHAR_W-1:0]    char_code,
  input  logic [tcw_pkg::ROW_W-1:0]     target_row,
  input  logic [tcw_pkg::COL_W-1:0]     target_col,
  input  logic                          init_busy,
  input  logic                          q_full,
  output logic                          q_push,
  output tcw_pkg::cmd_t                 q_cmd
);

  tcw_pkg::cmd_t cls;
  tcw_pkg::cmd_t stage_cmd;
  logic          stage_valid;
  logic          in_range;
  logic          accept;

  assign in_range = ({1'b0, target_row} < (tcw_pkg::ROW_W + 1)'(tcw_pkg::ROWS)) &&
                    ({1'b0, target_col} < (tcw_pkg::COL_W + 1)'(tcw_pkg::COLUMNS));

  always_comb begin
    cls.code = char_code;
    cls.row  = target_row;
    cls.col  = target_col;
    unique case (func)
      tcw_pkg::FN_WRITE: begin
        if (char_code == tcw_pkg::CH_BS) cls.op = tcw_pkg::OP_BS;
        else if (char_code == tcw_pkg::CH_TAB) cls.op = tcw_pkg::OP_TAB;
        else if (char_code == tcw_pkg::CH_NL) cls.op = tcw_pkg::OP_NL;
        else cls.op = tcw_pkg::OP_PUT;
      end
      tcw_pkg::FN_CLEAR:  cls.op = tcw_pkg::OP_CLEAR;
      tcw_pkg::FN_SETPOS: cls.op = in_range ? tcw_pkg::OP_SETPOS : tcw_pkg::OP_REPORT;
      default:            cls.op = in_range ? tcw_pkg::OP_READ : tcw_pkg::OP_REPORT;
    endcase
  end

  assign full   = init_busy || (stage_valid && q_full);
  assign accept = push && !full;
  assign q_push = stage_valid && !q_full;
  assign q_cmd  = stage_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (q_push) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_cmd <= cls;
    end
  end

endmodule

[rtl/core/tcw_cmd_fifo.sv]
// tcw_cmd_fifo: two-entry command queue between front and back.
// Depends on tcw_pkg for the command type.
module tcw_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  tcw_pkg::cmd_t wr_cmd,
  input  logic          pop,
  output logic          empty,
  output tcw_pkg::cmd_t rd_cmd
);

  tcw_pkg::cmd_t entries [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_cmd  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      if (do_push && !do_pop) count <= count + 2'd1;
      else if (do_pop && !do_push) count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

endmodule

[rtl/core/tcw_back.sv]
// tcw_back: executes console commands on the screen store and holds the cursor.
// Depends on tcw_pkg; takes commands from tcw_cmd_fifo, drives the result word.
module tcw_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [tcw_pkg::ATTR_W-1:0]  attr,
  input  logic                        q_empty,
  input  tcw_pkg::cmd_t               q_cmd,
  output logic                        q_pop,
  input  logic                        pop,
  output logic                        empty,
  output logic [tcw_pkg::COL_W-1:0]   cursor_col,
  output logic [tcw_pkg::ROW_W-1:0]   cursor_row,
  output logic [tcw_pkg::OFF_W-1:0]   cursor_offset,
  output logic [tcw_pkg::CELL_W-1:0]  cell_data,
  output tcw_pkg::status_t            status
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_READ   = 4'b0010,
    ST_SCROLL = 4'b0100,
    ST_FILL   = 4'b1000
  } state_t;

  state_t                        state;
  logic [tcw_pkg::CNT_W-1:0]     cnt;
  logic [tcw_pkg::CELL_W-1:0]    fill_val;
  logic                          rd_pend;
  logic [tcw_pkg::ADDR_W-1:0]    src_q;
  logic                          init_pass;
  logic [tcw_pkg::COL_W-1:0]     cur_col;
  logic [tcw_pkg::ROW_W-1:0]     cur_row;
  logic                          out_valid;
  logic [tcw_pkg::COL_W-1:0]     out_col;
  logic [tcw_pkg::ROW_W-1:0]     out_row;
  logic [tcw_pkg::OFF_W-1:0]     out_off;
  logic [tcw_pkg::CELL_W-1:0]    out_data;

  logic [tcw_pkg::CELL_W-1:0]    mem [tcw_pkg::CELLS];
  logic [tcw_pkg::CELL_W-1:0]    rdata;
  logic                          we;
  logic [tcw_pkg::ADDR_W-1:0]    waddr;
  logic [tcw_pkg::CELL_W-1:0]    wdata;
  logic [tcw_pkg::ADDR_W-1:0]    raddr;

  logic                          take;
  logic [tcw_pkg::COL_W:0]       nx;
  logic [tcw_pkg::ROW_W:0]       ny;
  logic                          scroll_need;
  logic [tcw_pkg::CELL_W-1:0]    blank;
  logic [tcw_pkg::ADDR_W-1:0]    char_addr;

  function automatic logic [tcw_pkg::ADDR_W-1:0] cell_addr(
      input logic [tcw_pkg::ROW_W-1:0] row, input logic [tcw_pkg::COL_W-1:0] col);
    logic [tcw_pkg::ADDR_W-1:0] r;
    r = tcw_pkg::ADDR_W'(row) * tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS) + tcw_pkg::ADDR_W'(col);
    return r;
  endfunction

  assign blank = {attr, tcw_pkg::CH_BLANK};
  assign take  = (state == ST_IDLE) && !out_valid && !q_empty;
  assign q_pop = take;

  always_comb begin
    nx = {1'b0, cur_col};
    ny = {1'b0, cur_row};
    case (q_cmd.op)
      tcw_pkg::OP_PUT: nx = {1'b0, cur_col} + 1'b1;
      tcw_pkg::OP_BS:  if (cur_col != '0) nx = {1'b0, cur_col} - 1'b1;
      tcw_pkg::OP_TAB: nx = ({1'b0, cur_col} + (tcw_pkg::COL_W + 1)'(tcw_pkg::TAB_STEP)) &
                            ~(tcw_pkg::COL_W + 1)'(tcw_pkg::TAB_STEP - 1);
      tcw_pkg::OP_NL: begin
        nx = '0;
        ny = {1'b0, cur_row} + 1'b1;
      end
      default: ;
    endcase
    if (nx >= (tcw_pkg::COL_W + 1)'(tcw_pkg::COLUMNS)) begin
      nx = '0;
      ny = {1'b0, cur_row} + 1'b1;
    end
    scroll_need = (ny >= (tcw_pkg::ROW_W + 1)'(tcw_pkg::ROWS));
  end

  assign char_addr = cell_addr(cur_row, nx[tcw_pkg::COL_W-1:0]);

  always_comb begin
    we    = 1'b0;
    waddr = char_addr;
    wdata = blank;
    raddr = cell_addr(q_cmd.row, q_cmd.col);
    unique case (state)
      ST_FILL: begin
        we    = 1'b1;
        waddr = cnt[tcw_pkg::ADDR_W-1:0];
        wdata = fill_val;
      end
      ST_SCROLL: begin
        we    = rd_pend;
        waddr = src_q - tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS);
        wdata = rdata;
        raddr = cnt[tcw_pkg::ADDR_W-1:0];
      end
      ST_IDLE: begin
        if (take && q_cmd.op == tcw_pkg::OP_PUT) begin
          we    = 1'b1;
          waddr = cell_addr(cur_row, cur_col);
          wdata = {attr, q_cmd.code};
        end else if (take && q_cmd.op == tcw_pkg::OP_BS) begin
          we = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_FILL;
      cnt       <= '0;
      fill_val  <= '0;
      init_pass <= 1'b1;
      rd_pend   <= 1'b0;
      cur_col   <= '0;
      cur_row   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop && out_valid) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (take) begin
            out_valid <= (q_cmd.op != tcw_pkg::OP_READ);
            out_data  <= '0;
            case (q_cmd.op)
              tcw_pkg::OP_CLEAR: begin
                cur_col  <= '0;
                cur_row  <= '0;
                out_col  <= '0;
                out_row  <= '0;
                out_off  <= '0;
                state    <= ST_FILL;
                cnt      <= '0;
                fill_val <= blank;
              end
              tcw_pkg::OP_SETPOS: begin
                cur_col <= q_cmd.col;
                cur_row <= q_cmd.row;
                out_col <= q_cmd.col;
                out_row <= q_cmd.row;
                out_off <= tcw_pkg::cell_offset(q_cmd.row, q_cmd.col);
              end
              tcw_pkg::OP_READ: begin
                state <= ST_READ;
              end
              tcw_pkg::OP_REPORT: begin
                out_col <= cur_col;
                out_row <= cur_row;
                out_off <= tcw_pkg::cell_offset(cur_row, cur_col);
              end
              default: begin
                cur_col <= nx[tcw_pkg::COL_W-1:0];
                out_col <= nx[tcw_pkg::COL_W-1:0];
                if (scroll_need) begin
                  cur_row  <= tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
                  out_row  <= tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
                  out_off  <= tcw_pkg::cell_offset(tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1),
                                                   nx[tcw_pkg::COL_W-1:0]);
                  state    <= ST_SCROLL;
                  cnt      <= tcw_pkg::CNT_W'(tcw_pkg::COLUMNS);
                  rd_pend  <= 1'b0;
                  fill_val <= blank;
                end else begin
                  cur_row <= ny[tcw_pkg::ROW_W-1:0];
                  out_row <= ny[tcw_pkg::ROW_W-1:0];
                  out_off <= tcw_pkg::cell_offset(ny[tcw_pkg::ROW_W-1:0],
                                                  nx[tcw_pkg::COL_W-1:0]);
                end
              end
            endcase
          end
        end
        ST_READ: begin
          out_valid <= 1'b1;
          out_col   <= cur_col;
          out_row   <= cur_row;
          out_off   <= tcw_pkg::cell_offset(cur_row, cur_col);
          out_data  <= rdata;
          state     <= ST_IDLE;
        end
        ST_SCROLL: begin
          if (cnt < tcw_pkg::CNT_W'(tcw_pkg::CELLS)) begin
            cnt     <= cnt + 1'b1;
            rd_pend <= 1'b1;
            src_q   <= cnt[tcw_pkg::ADDR_W-1:0];
          end else begin
            rd_pend <= 1'b0;
            state   <= ST_FILL;
            cnt     <= tcw_pkg::CNT_W'((tcw_pkg::ROWS - 1) * tcw_pkg::COLUMNS);
          end
        end
        ST_FILL: begin
          if (cnt == tcw_pkg::CNT_W'(tcw_pkg::CELLS - 1)) begin
            state     <= ST_IDLE;
            init_pass <= 1'b0;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign empty            = !out_valid;
  assign cursor_col       = out_col;
  assign cursor_row       = out_row;
  assign cursor_offset    = out_off;
  assign cell_data        = out_data;
  assign status.init_busy = init_pass;
  assign status.busy      = (state != ST_IDLE);

endmodule

[test/tb_text_console_writer.sv]
// Self-checking bench for text_console_writer: queue-style push/pop handshakes
// and APB attribute writes, checked against an in-bench model of the screen.
// Depends on tcw_pkg and the text_console_writer RTL only.
`timescale 1ns / 1ps

module tb_text_console_writer;
  import tcw_pkg::*;

  localparam logic [APB_ADDR_W-1:0] ATTR_ADDR = APB_ADDR_W'(4 * int'(REG_TEXT_ATTRIBUTE));
  localparam int RANDOM_PHASES = 5;
  localparam int PHASE_WORDS = 140;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [CHAR_W-1:0] char_code;
    logic [ROW_W-1:0]  target_row;
    logic [COL_W-1:0]  target_col;
  } console_word_t;

  typedef struct packed {
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic [OFF_W-1:0]  cursor_offset;
    logic [CELL_W-1:0] cell_data;
  } cursor_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic [FUNC_W-1:0] func = FN_READ;
  logic [CHAR_W-1:0] char_code = '0;
  logic [ROW_W-1:0] target_row = '0;
  logic [COL_W-1:0] target_col = '0;
  logic empty;
  logic pop = 1'b0;
  logic [COL_W-1:0] cursor_col;
  logic [ROW_W-1:0] cursor_row;
  logic [OFF_W-1:0] cursor_offset;
  logic [CELL_W-1:0] cell_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  text_console_writer dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .func(func), .char_code(char_code),
    .target_row(target_row), .target_col(target_col), .empty(empty), .pop(pop),
    .cursor_col(cursor_col), .cursor_row(cursor_row), .cursor_offset(cursor_offset),
    .cell_data(cell_data), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  console_word_t  words_pending[$];
  cursor_report_t reports_due[$];
  console_word_t  offered;

  logic [CELL_W-1:0] screen_model [CELLS];
  int cur_col = 0;
  int cur_row = 0;
  logic [ATTR_W-1:0] text_attr = ATTR_RESET;

  int mismatches = 0;
  int words_accepted = 0;
  int reports_checked = 0;
  int words_queued = 0;
  int scrolls_seen = 0;
  int clears_seen = 0;
  int reads_seen = 0;
  int attrs_written = 0;
  bit calm = 1'b0;
  int hold_left = 0;
  int holds_done = 0;

  function automatic bit take_break();
    return !calm && ($urandom_range(99) < 38);
  endfunction

  task automatic note_mismatch(input string field, input int unsigned want,
                               input int unsigned got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on report %0d, %s: expected %0h, got %0h",
               reports_checked, field, want, got);
  endtask

  task automatic advance_console(input console_word_t w, output cursor_report_t r);
    int x;
    int y;
    int i;
    logic [CELL_W-1:0] blank;
    blank = {text_attr, CH_BLANK};
    r = '0;
    case (w.func)
      FN_WRITE: begin
        x = cur_col;
        y = cur_row;
        if (w.char_code == CH_NL) begin
          x = 0;
          y++;
        end else if (w.char_code == CH_TAB) begin
          x = (x + TAB_STEP) & ~(TAB_STEP - 1);
        end else if (w.char_code == CH_BS) begin
          if (x > 0) x--;
          screen_model[y * COLUMNS + x] = blank;
        end else begin
          screen_model[y * COLUMNS + x] = {text_attr, w.char_code};
          x++;
        end
        if (x >= COLUMNS) begin
          x = 0;
          y++;
        end
        cur_col = x;
        cur_row = y;
        if (y >= ROWS) begin
          for (i = 0; i < (ROWS - 1) * COLUMNS; i++) screen_model[i] = screen_model[i + COLUMNS];
          for (i = (ROWS - 1) * COLUMNS; i < CELLS; i++) screen_model[i] = blank;
          cur_row = ROWS - 1;
          scrolls_seen++;
        end
      end
      FN_CLEAR: begin
        for (i = 0; i < CELLS; i++) screen_model[i] = blank;
        cur_col = 0;
        cur_row = 0;
        clears_seen++;
      end
      FN_SETPOS: begin
        if (w.target_row < ROWS && w.target_col < COLUMNS) begin
          cur_row = w.target_row;
          cur_col = w.target_col;
        end
      end
      default: begin
        reads_seen++;
        if (w.target_row < ROWS && w.target_col < COLUMNS)
          r.cell_data = screen_model[w.target_row * COLUMNS + w.target_col];
      end
    endcase
    r.cursor_col = COL_W'(cur_col);
    r.cursor_row = ROW_W'(cur_row);
    r.cursor_offset = OFF_W'(cur_row * COLUMNS + cur_col);
  endtask

  // Driver: hold the offered word until accepted, then advance.
  always @(posedge clk) begin
    cursor_report_t r;
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        advance_console(offered, r);
        reports_due.push_back(r);
        words_accepted++;
      end
      if (!push || !full) begin
        if (words_pending.size() > 0 && !take_break()) begin
          offered = words_pending.pop_front();
          func <= offered.func;
          char_code <= offered.char_code;
          target_row <= offered.target_row;
          target_col <= offered.target_col;
          push <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-offs so the block backs up and raises full.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_done < 2 && words_accepted >= 150 + 300 * holds_done) begin
      hold_left <= 400;
      holds_done <= holds_done + 1;
    end
  end

  // Monitor: compare each popped word with the oldest prediction.
  always @(posedge clk) begin
    cursor_report_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        reports_checked++;
        if (reports_due.size() == 0) begin
          note_mismatch("unexpected word", 0, {cursor_row, cursor_col});
        end else begin
          want = reports_due.pop_front();
          if (cursor_col !== want.cursor_col)
            note_mismatch("cursor_col", want.cursor_col, cursor_col);
          if (cursor_row !== want.cursor_row)
            note_mismatch("cursor_row", want.cursor_row, cursor_row);
          if (cursor_offset !== want.cursor_offset)
            note_mismatch("cursor_offset", want.cursor_offset, cursor_offset);
          if (cell_data !== want.cell_data)
            note_mismatch("cell_data", want.cell_data, cell_data);
        end
      end
      pop <= (hold_left == 0) && !take_break();
    end
  end

  task automatic enqueue(input logic [FUNC_W-1:0] f, input logic [CHAR_W-1:0] c,
                         input int r, input int k);
    console_word_t w;
    w.func = f;
    w.char_code = c;
    w.target_row = ROW_W'(r);
    w.target_col = COL_W'(k);
    words_pending.push_back(w);
    words_queued++;
  endtask

  function automatic logic [CHAR_W-1:0] pick_char();
    int r;
    r = $urandom_range(99);
    if (r < 8) return CH_NL;
    if (r < 16) return CH_TAB;
    if (r < 24) return CH_BS;
    return CHAR_W'($urandom_range(255));
  endfunction

  task automatic queue_burst();
    int kind;
    int n;
    int i;
    int row;
    kind = $urandom_range(99);
    if (kind < 45) begin
      // text run from a chosen position, often near the bottom to force scrolls
      row = ($urandom_range(99) < 30) ? $urandom_range(ROWS - 1, ROWS - 3)
                                      : $urandom_range(ROWS - 1);
      enqueue(FN_SETPOS, CHAR_W'($urandom_range(255)), row, $urandom_range(COLUMNS - 1));
      n = $urandom_range(24, 4);
      for (i = 0; i < n; i++) enqueue(FN_WRITE, pick_char(), $urandom_range(31),
                                      $urandom_range(127));
    end else if (kind < 70) begin
      n = $urandom_range(8, 2);
      for (i = 0; i < n; i++) begin
        if ($urandom_range(99) < 15)
          enqueue(FN_READ, CHAR_W'($urandom_range(255)), $urandom_range(31),
                  $urandom_range(127));
        else
          enqueue(FN_READ, CHAR_W'($urandom_range(255)), $urandom_range(ROWS - 1),
                  $urandom_range(COLUMNS - 1));
      end
    end else if (kind < 95) begin
      n = $urandom_range(3);
      if (n == FN_CLEAR && $urandom_range(9) != 0) n = FN_WRITE;
      enqueue(FUNC_W'(n), CHAR_W'($urandom_range(255)), $urandom_range(31),
              $urandom_range(127));
    end else begin
      enqueue(FN_CLEAR, CHAR_W'($urandom_range(255)), $urandom_range(31),
              $urandom_range(127));
      for (i = 0; i < 3; i++)
        enqueue(FN_READ, '0, $urandom_range(ROWS - 1), $urandom_range(COLUMNS - 1));
    end
  endtask

  task automatic wait_drained();
    while (words_pending.size() != 0 || push || reports_due.size() != 0 || full)
      @(posedge clk);
  endtask

  task automatic write_attribute(input logic [ATTR_W-1:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ATTR_ADDR;
    pwdata <= APB_DATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    text_attr = v;
    attrs_written++;
  endtask

  task automatic check_attribute();
    logic [APB_DATA_W-1:0] got;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ATTR_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    got = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (got !== APB_DATA_W'(text_attr)) note_mismatch("text_attribute readback", text_attr, got);
  endtask

  initial begin
    logic [ATTR_W-1:0] attr_plan [RANDOM_PHASES];
    int p;
    for (p = 0; p < CELLS; p++) screen_model[p] = '0;
    attr_plan[0] = 8'h00;
    attr_plan[1] = 8'hFF;
    attr_plan[2] = ATTR_W'($urandom_range(255));
    attr_plan[3] = ATTR_W'($urandom_range(255));
    attr_plan[4] = 8'h70;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    wait_drained();
    check_attribute();

    // directed: field extremes, every operation and the edge cases
    enqueue(FN_READ, 8'h00, 0, 0);
    enqueue(FN_WRITE, 8'h41, 0, 0);
    enqueue(FN_WRITE, 8'hFF, 31, 127);
    enqueue(FN_WRITE, 8'h00, 0, 0);
    enqueue(FN_READ, 8'hFF, 0, 1);
    enqueue(FN_READ, 8'h00, 0, 2);
    enqueue(FN_SETPOS, 8'h00, ROWS, 0);
    enqueue(FN_SETPOS, 8'h00, 0, COLUMNS);
    enqueue(FN_SETPOS, 8'h00, 31, 127);
    enqueue(FN_READ, 8'h00, 31, 127);
    enqueue(FN_READ, 8'h00, ROWS - 1, COLUMNS - 1);
    enqueue(FN_SETPOS, 8'h00, 3, 0);
    enqueue(FN_WRITE, CH_BS, 0, 0);
    enqueue(FN_READ, 8'h00, 3, 0);
    enqueue(FN_SETPOS, 8'h00, ROWS - 1, COLUMNS - 5);
    enqueue(FN_WRITE, CH_TAB, 0, 0);
    enqueue(FN_SETPOS, 8'h00, ROWS - 1, COLUMNS - 1);
    enqueue(FN_WRITE, 8'h5A, 0, 0);
    enqueue(FN_READ, 8'h00, ROWS - 2, COLUMNS - 1);
    enqueue(FN_WRITE, CH_NL, 0, 0);
    enqueue(FN_SETPOS, 8'h00, 10, 5);
    enqueue(FN_WRITE, CH_TAB, 0, 0);
    enqueue(FN_CLEAR, 8'h00, 0, 0);
    enqueue(FN_READ, 8'h00, 12, 40);
    wait_drained();

    for (p = 0; p < RANDOM_PHASES; p++) begin
      write_attribute(attr_plan[p]);
      check_attribute();
      calm = (p == 2);
      words_queued = 0;
      while (words_queued < PHASE_WORDS) queue_burst();
      wait_drained();
    end
    calm = 1'b0;
    repeat (40) @(posedge clk);

    $display("ran %0d words (%0d reads, %0d scrolls, %0d clears) over %0d attribute settings",
             words_accepted, reads_seen, scrolls_seen, clears_seen, attrs_written + 1);
    $display("checked %0d result words, %0d mismatches", reports_checked, mismatches);
    if (mismatches == 0 && reports_due.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin
    #60_000_000;
    $display("timeout with %0d result words outstanding", reports_due.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule
